// File: rtl/cct_pkg.sv
package cct_pkg;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int U_W     = FRAC_W + 1;
   localparam int STEP_W  = 6;
   localparam int WIDE_W  = 36;
   localparam int SUM_W   = 38;

   localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_W;

   localparam logic CSR_CURVE_KIND = 1'b0;
   localparam logic CSR_STEPS      = 1'b1;

   localparam logic KIND_BEZIER = 1'b0;
   localparam logic KIND_CATMULL = 1'b1;

   localparam logic signed [SUM_W-1:0] SAT_HI = 38'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_LO = -38'sd2147483648;

   typedef logic [3:0][COORD_W-1:0] window_type;

   typedef struct packed {
      window_type        wx;
      window_type        wy;
      window_type        wz;
      logic              kind;
      logic [STEP_W-1:0] steps;
      logic              seg;
      logic              is_end;
   } job_type;

   // floor(2^16 / s)
   function automatic logic [U_W-1:0] step_quot(input logic [STEP_W-1:0] s);
      logic [U_W-1:0] q;
      unique case (s)
         6'd1:  q = 17'd65536;  6'd2:  q = 17'd32768;  6'd3:  q = 17'd21845;
         6'd4:  q = 17'd16384;  6'd5:  q = 17'd13107;  6'd6:  q = 17'd10922;
         6'd7:  q = 17'd9362;   6'd8:  q = 17'd8192;   6'd9:  q = 17'd7281;
         6'd10: q = 17'd6553;   6'd11: q = 17'd5957;   6'd12: q = 17'd5461;
         6'd13: q = 17'd5041;   6'd14: q = 17'd4681;   6'd15: q = 17'd4369;
         6'd16: q = 17'd4096;   6'd17: q = 17'd3855;   6'd18: q = 17'd3640;
         6'd19: q = 17'd3449;   6'd20: q = 17'd3276;   6'd21: q = 17'd3120;
         6'd22: q = 17'd2978;   6'd23: q = 17'd2849;   6'd24: q = 17'd2730;
         6'd25: q = 17'd2621;   6'd26: q = 17'd2520;   6'd27: q = 17'd2427;
         6'd28: q = 17'd2340;   6'd29: q = 17'd2259;   6'd30: q = 17'd2184;
         6'd31: q = 17'd2114;   6'd32: q = 17'd2048;   6'd33: q = 17'd1985;
         6'd34: q = 17'd1927;   6'd35: q = 17'd1872;   6'd36: q = 17'd1820;
         6'd37: q = 17'd1771;   6'd38: q = 17'd1724;   6'd39: q = 17'd1680;
         6'd40: q = 17'd1638;   6'd41: q = 17'd1598;   6'd42: q = 17'd1560;
         6'd43: q = 17'd1524;   6'd44: q = 17'd1489;   6'd45: q = 17'd1456;
         6'd46: q = 17'd1424;   6'd47: q = 17'd1394;   6'd48: q = 17'd1365;
         6'd49: q = 17'd1337;   6'd50: q = 17'd1310;   6'd51: q = 17'd1285;
         6'd52: q = 17'd1260;   6'd53: q = 17'd1236;   6'd54: q = 17'd1213;
         6'd55: q = 17'd1191;   6'd56: q = 17'd1170;   6'd57: q = 17'd1149;
         6'd58: q = 17'd1129;   6'd59: q = 17'd1110;   6'd60: q = 17'd1092;
         6'd61: q = 17'd1074;   6'd62: q = 17'd1057;   6'd63: q = 17'd1040;
         default: q = 17'd65536;
      endcase
      return q;
   endfunction

   function automatic logic [STEP_W-1:0] step_rem(input logic [STEP_W-1:0] s);
      logic [U_W+STEP_W-1:0] prod;
      logic [U_W+STEP_W-1:0] rem;
      prod = (U_W+STEP_W)'(step_quot(s)) * (U_W+STEP_W)'(s);
      rem  = (U_W+STEP_W)'(U_ONE) - prod;
      return rem[STEP_W-1:0];
   endfunction

   // floor(a * u / 2^16)
   function automatic logic signed [WIDE_W-1:0] mul_q(input logic signed [WIDE_W-1:0] a,
                                                     input logic [U_W-1:0] u);
      logic signed [WIDE_W+U_W:0] prod;
      prod = (WIDE_W+U_W+1)'(a) * $signed({{WIDE_W{1'b0}}, u});
      return prod[WIDE_W+FRAC_W-1:FRAC_W];
   endfunction

   function automatic logic signed [COORD_W-1:0] lerp_q(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b,
                                                       input logic [U_W-1:0] u);
      logic signed [WIDE_W-1:0] d;
      logic signed [WIDE_W-1:0] m;
      d = WIDE_W'(b) - WIDE_W'(a);
      m = mul_q(d, u);
      return a + $signed(m[COORD_W-1:0]);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/cct_front.sv
module cct_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [cct_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [cct_pkg::COORD_W-1:0] req_point_y,
   input  logic signed [cct_pkg::COORD_W-1:0] req_point_z,
   input  logic                              req_curve_end,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [cct_pkg::STEP_W-1:0]        csr_wdata,
   input  logic                              q_full,
   output logic                              push_valid,
   output cct_pkg::job_type                  push_job
);

   logic                       kind_ff, kind_in;
   logic [cct_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic                       seen_ff, seen_in;
   cct_pkg::window_type        wx_ff, wy_ff, wz_ff, wx_in, wy_in, wz_in;
   cct_pkg::window_type        wx_new, wy_new, wz_new;
   logic [cct_pkg::COORD_W-1:0] ex_ff, ey_ff, ez_ff, ex_in, ey_in, ez_in;
   logic [cct_pkg::STEP_W-1:0] steps_eff;
   logic                       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign steps_eff = (steps_ff == '0) ? cct_pkg::STEP_W'(1) : steps_ff;

   always_comb begin
      kind_in  = kind_ff;
      steps_in = steps_ff;
      if (csr_we) begin
         unique case (csr_index)
            cct_pkg::CSR_CURVE_KIND: kind_in  = csr_wdata[0];
            cct_pkg::CSR_STEPS:      steps_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      wx_new = wx_ff;
      wy_new = wy_ff;
      wz_new = wz_ff;
      wx_new[cnt_ff] = req_point_x;
      wy_new[cnt_ff] = req_point_y;
      wz_new[cnt_ff] = req_point_z;

      wx_in = wx_ff;
      wy_in = wy_ff;
      wz_in = wz_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      ez_in = ez_ff;
      cnt_in  = cnt_ff;
      seen_in = seen_ff;

      push_valid      = 1'b0;
      push_job.wx     = wx_new;
      push_job.wy     = wy_new;
      push_job.wz     = wz_new;
      push_job.kind   = kind_ff;
      push_job.steps  = steps_eff;
      push_job.seg    = 1'b1;
      push_job.is_end = req_curve_end;

      if (accept) begin
         if (cnt_ff == 2'd3) begin
            push_valid = 1'b1;
            seen_in    = 1'b1;
            if (kind_ff == cct_pkg::KIND_BEZIER) begin
               ex_in = wx_new[3];
               ey_in = wy_new[3];
               ez_in = wz_new[3];
               wx_in = wx_new;
               wy_in = wy_new;
               wz_in = wz_new;
               wx_in[0] = wx_new[3];
               wy_in[0] = wy_new[3];
               wz_in[0] = wz_new[3];
               cnt_in = 2'd1;
            end else begin
               ex_in = wx_new[2];
               ey_in = wy_new[2];
               ez_in = wz_new[2];
               wx_in = {wx_new[3], wx_new[3], wx_new[2], wx_new[1]};
               wy_in = {wy_new[3], wy_new[3], wy_new[2], wy_new[1]};
               wz_in = {wz_new[3], wz_new[3], wz_new[2], wz_new[1]};
               cnt_in = 2'd3;
            end
         end else begin
            wx_in  = wx_new;
            wy_in  = wy_new;
            wz_in  = wz_new;
            cnt_in = cnt_ff + 2'd1;
            if (req_curve_end && seen_ff) begin
               // a window of four copies of the end point evaluates to it at u=1
               push_valid   = 1'b1;
               push_job.wx  = {4{ex_ff}};
               push_job.wy  = {4{ey_ff}};
               push_job.wz  = {4{ez_ff}};
               push_job.seg = 1'b0;
            end
         end
         if (req_curve_end) begin
            cnt_in  = 2'd0;
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= cct_pkg::KIND_BEZIER;
         steps_ff <= cct_pkg::STEP_W'(16);
         cnt_ff   <= 2'd0;
         seen_ff  <= 1'b0;
      end else begin
         kind_ff  <= kind_in;
         steps_ff <= steps_in;
         cnt_ff   <= cnt_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff <= wx_in;
      wy_ff <= wy_in;
      wz_ff <= wz_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      ez_ff <= ez_in;
   end

endmodule

// File: rtl/cct_queue.sv
module cct_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cct_pkg::job_type push_job,
   input  logic             pop,
   output cct_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);

   cct_pkg::job_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/cct_eval.sv
module cct_eval (
   input  logic                              clock,
   input  logic                              en,
   input  cct_pkg::window_type               p,
   input  logic [cct_pkg::U_W-1:0]           u,
   input  logic                              kind,
   output logic signed [cct_pkg::COORD_W-1:0] result
);

   localparam int CW = cct_pkg::COORD_W;
   localparam int WW = cct_pkg::WIDE_W;
   localparam int SW = cct_pkg::SUM_W;
   localparam int UW = cct_pkg::U_W;

   logic signed [CW-1:0] p0, p1, p2, p3;
   logic signed [WW-1:0] s0, s1, s2, s3;

   logic signed [CW-1:0] l1a_ff, l1b_ff, l1c_ff, l1a_in, l1b_in, l1c_in;
   logic signed [WW-1:0] c1_ff, c2_ff, c3a_ff, c1_in, c2_in, c3_in;
   logic signed [SW-1:0] twop1a_ff, twop1_in;
   logic [UW-1:0]        u2_ff, u2_in, ua_ff;
   logic                 kinda_ff;
   logic [2*UW-1:0]      uu, uuu;

   logic signed [CW-1:0] l2a_ff, l2b_ff, l2a_in, l2b_in;
   logic signed [WW-1:0] m1_ff, m2_ff, c3b_ff, m1_in, m2_in;
   logic signed [SW-1:0] twop1b_ff;
   logic [UW-1:0]        u3_ff, u3_in, ub_ff;
   logic                 kindb_ff;

   logic signed [CW-1:0] bez;
   logic signed [WW-1:0] m3;
   logic signed [SW-1:0] sum, half;

   always_comb begin
      p0 = $signed(p[0]);
      p1 = $signed(p[1]);
      p2 = $signed(p[2]);
      p3 = $signed(p[3]);
      s0 = WW'(p0);
      s1 = WW'(p1);
      s2 = WW'(p2);
      s3 = WW'(p3);
      l1a_in   = cct_pkg::lerp_q(p0, p1, u);
      l1b_in   = cct_pkg::lerp_q(p1, p2, u);
      l1c_in   = cct_pkg::lerp_q(p2, p3, u);
      c1_in    = s2 - s0;
      c2_in    = (s0 <<< 1) - (s1 <<< 2) - s1 + (s2 <<< 2) - s3;
      c3_in    = (s1 <<< 1) + s1 - s0 - (s2 <<< 1) - s2 + s3;
      twop1_in = SW'(p1) <<< 1;
      uu       = (2*UW)'(u) * (2*UW)'(u);
      u2_in    = uu[UW+cct_pkg::FRAC_W-1:cct_pkg::FRAC_W];
   end

   always_comb begin
      l2a_in = cct_pkg::lerp_q(l1a_ff, l1b_ff, ua_ff);
      l2b_in = cct_pkg::lerp_q(l1b_ff, l1c_ff, ua_ff);
      uuu    = (2*UW)'(u2_ff) * (2*UW)'(ua_ff);
      u3_in  = uuu[UW+cct_pkg::FRAC_W-1:cct_pkg::FRAC_W];
      m1_in  = cct_pkg::mul_q(c1_ff, ua_ff);
      m2_in  = cct_pkg::mul_q(c2_ff, u2_ff);
   end

   always_comb begin
      bez  = cct_pkg::lerp_q(l2a_ff, l2b_ff, ub_ff);
      m3   = cct_pkg::mul_q(c3b_ff, u3_ff);
      sum  = twop1b_ff + SW'(m1_ff) + SW'(m2_ff) + SW'(m3);
      half = sum >>> 1;
      result = (kindb_ff == cct_pkg::KIND_CATMULL) ? cct_pkg::sat_q(half) : bez;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1a_ff    <= l1a_in;
         l1b_ff    <= l1b_in;
         l1c_ff    <= l1c_in;
         c1_ff     <= c1_in;
         c2_ff     <= c2_in;
         c3a_ff    <= c3_in;
         twop1a_ff <= twop1_in;
         u2_ff     <= u2_in;
         ua_ff     <= u;
         kinda_ff  <= kind;

         l2a_ff    <= l2a_in;
         l2b_ff    <= l2b_in;
         m1_ff     <= m1_in;
         m2_ff     <= m2_in;
         c3b_ff    <= c3a_ff;
         twop1b_ff <= twop1a_ff;
         u3_ff     <= u3_in;
         ub_ff     <= ua_ff;
         kindb_ff  <= kinda_ff;
      end
   end

endmodule

// File: rtl/cct_back.sv
module cct_back (
   input  logic                               clock,
   input  logic                               reset,
   input  cct_pkg::job_type                   head_job,
   input  logic                               q_empty,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_x,
   output logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_y,
   output logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_z,
   output logic                               rsp_run_last,
   output logic                               rsp_polyline_last
);

   localparam int UW = cct_pkg::U_W;
   localparam int SW = cct_pkg::STEP_W;

   cct_pkg::job_type job_ff;
   logic             busy_ff, busy_in;
   logic             fin_ff, fin_in;
   logic [SW-1:0]    k_ff, k_in;
   logic [UW-1:0]    q_ff, q_in;
   logic [SW-1:0]    r_ff, r_in;
   logic [SW:0]      r_sum;

   logic             en, issue, k_last;
   logic [UW-1:0]    u_cur;
   logic             last_cur;

   logic             v1_ff, v2_ff, out_v_ff;
   logic             last1_ff, last2_ff, pl1_ff, pl2_ff;
   logic signed [cct_pkg::COORD_W-1:0] ex, ey, ez;
   logic signed [cct_pkg::COORD_W-1:0] vx_ff, vy_ff, vz_ff;
   logic             out_last_ff, out_pl_ff;

   assign en       = !(out_v_ff && rsp_stall);
   assign issue    = busy_ff && en;
   assign pop      = !busy_ff && !q_empty;
   assign k_last   = (k_ff == job_ff.steps - SW'(1));
   assign u_cur    = fin_ff ? cct_pkg::U_ONE : q_ff;
   assign last_cur = fin_ff || (k_last && !job_ff.is_end);

   always_comb begin
      busy_in = busy_ff;
      fin_in  = fin_ff;
      k_in    = k_ff;
      q_in    = q_ff + cct_pkg::step_quot(job_ff.steps);
      r_sum   = {1'b0, r_ff} + {1'b0, cct_pkg::step_rem(job_ff.steps)};
      r_in    = r_sum[SW-1:0];
      if (r_sum >= {1'b0, job_ff.steps}) begin
         r_in = r_sum[SW-1:0] - job_ff.steps;
         q_in = q_in + UW'(1);
      end
      if (pop) begin
         busy_in = 1'b1;
         fin_in  = !head_job.seg;
         k_in    = '0;
         q_in    = '0;
         r_in    = '0;
      end else if (issue) begin
         if (fin_ff) begin
            busy_in = 1'b0;
         end else if (k_last) begin
            if (job_ff.is_end) begin
               fin_in = 1'b1;
            end else begin
               busy_in = 1'b0;
            end
         end else begin
            k_in = k_ff + SW'(1);
         end
      end else begin
         q_in = q_ff;
         r_in = r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (en) begin
            v1_ff    <= issue;
            v2_ff    <= v1_ff;
            out_v_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      k_ff   <= k_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      if (pop) begin
         job_ff <= head_job;
      end
      if (en) begin
         last1_ff    <= last_cur;
         pl1_ff      <= fin_ff;
         last2_ff    <= last1_ff;
         pl2_ff      <= pl1_ff;
         vx_ff       <= ex;
         vy_ff       <= ey;
         vz_ff       <= ez;
         out_last_ff <= last2_ff;
         out_pl_ff   <= pl2_ff;
      end
   end

   cct_eval u_eval_x (
      .clock  (clock),
      .en     (en),
      .p      (job_ff.wx),
      .u      (u_cur),
      .kind   (job_ff.kind),
      .result (ex)
   );

   cct_eval u_eval_y (
      .clock  (clock),
      .en     (en),
      .p      (job_ff.wy),
      .u      (u_cur),
      .kind   (job_ff.kind),
      .result (ey)
   );

   cct_eval u_eval_z (
      .clock  (clock),
      .en     (en),
      .p      (job_ff.wz),
      .u      (u_cur),
      .kind   (job_ff.kind),
      .result (ez)
   );

   assign rsp_valid         = out_v_ff;
   assign rsp_vertex_x      = vx_ff;
   assign rsp_vertex_y      = vy_ff;
   assign rsp_vertex_z      = vz_ff;
   assign rsp_run_last      = out_last_ff;
   assign rsp_polyline_last = out_pl_ff;

endmodule

// File: rtl/cubic_curve_tessellator_top.sv
// Cubic curve tessellator.
// req_*: one control point per item (signed Q16 x/y/z) and curve_end on the
// last point of a curve. rsp_*: one vertex per item, with run_last on the last
// vertex caused by a point and polyline_last on the u=1 vertex ending a curve.
// csr_*: index 0 selects Bezier (0) or Catmull-Rom (1), index 1 the steps per
// segment; write only while the block is idle.
// The front keeps the point window and queues a job per completed segment (or
// per curve end) in a two-entry queue; it stalls req_* only when that queue is
// full. The back steps u once per cycle, unless rsp_stall holds it, through a
// three-stage evaluator; a segment issues steps vertices, plus the end vertex
// if it ends a curve, and a job is loaded only once the previous one has issued
// its last vertex. rsp_stall freezes the whole evaluator while a vertex waits
// on rsp_*; a waiting vertex holds its value.
// Reset (synchronous) empties the window, the queue and the pipeline and sets
// Bezier with 16 steps.
module cubic_curve_tessellator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [cct_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [cct_pkg::COORD_W-1:0] req_point_y,
   input  logic signed [cct_pkg::COORD_W-1:0] req_point_z,
   input  logic                               req_curve_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_x,
   output logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_y,
   output logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_z,
   output logic                               rsp_run_last,
   output logic                               rsp_polyline_last,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [cct_pkg::STEP_W-1:0]         csr_wdata
);

   cct_pkg::job_type push_job, head_job;
   logic             push_valid, q_full, q_empty, pop;

   cct_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_curve_end (req_curve_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   cct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   cct_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .q_empty           (q_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_vertex_z      (rsp_vertex_z),
      .rsp_run_last      (rsp_run_last),
      .rsp_polyline_last (rsp_polyline_last)
   );

endmodule

// File: tb/sv/tb_cubic_curve_tessellator_top.sv
`timescale 1ns / 100ps

module tb_cubic_curve_tessellator_top;

   localparam longint ONE_Q     = 64'sd65536;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;
   localparam int     LIMIT     = 2000000;

   typedef struct {
      logic signed [cct_pkg::COORD_W-1:0] x;
      logic signed [cct_pkg::COORD_W-1:0] y;
      logic signed [cct_pkg::COORD_W-1:0] z;
      logic                               run_last;
      logic                               poly_last;
   } vertex_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [cct_pkg::COORD_W-1:0] req_point_x = '0;
   logic signed [cct_pkg::COORD_W-1:0] req_point_y = '0;
   logic signed [cct_pkg::COORD_W-1:0] req_point_z = '0;
   logic                               req_curve_end = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_x;
   logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_y;
   logic signed [cct_pkg::COORD_W-1:0] rsp_vertex_z;
   logic                               rsp_run_last;
   logic                               rsp_polyline_last;
   logic                               csr_we = 1'b0;
   logic                               csr_index = 1'b0;
   logic [cct_pkg::STEP_W-1:0]         csr_wdata = '0;

   vertex_type vertex_q[$];
   int      errors = 0;
   int      cycles = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      hold_cycles = 0;

   // shadow state of the tessellator
   longint  win_x[4], win_y[4], win_z[4];
   int      win_count = 0;
   bit      seg_done = 1'b0;
   longint  tail_x, tail_y, tail_z;
   logic    kind_reg = cct_pkg::KIND_BEZIER;
   int      steps_reg = 16;

   cubic_curve_tessellator_top u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("cubic_curve_tessellator_top: mismatch");
         $finish;
      end
   end

   function automatic longint clamp_coord(input longint v);
      return v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v);
   endfunction

   function automatic longint lerp_fx(input longint a, input longint b, input longint u);
      return a + (((b - a) * u) >>> 16);
   endfunction

   function automatic longint curve_point(input longint w[4], input longint u);
      longint a, b, c, u2, u3, s;
      if (kind_reg == cct_pkg::KIND_BEZIER) begin
         a = lerp_fx(w[0], w[1], u);
         b = lerp_fx(w[1], w[2], u);
         c = lerp_fx(w[2], w[3], u);
         return clamp_coord(lerp_fx(lerp_fx(a, b, u), lerp_fx(b, c, u), u));
      end
      u2 = (u * u) >>> 16;
      u3 = (u2 * u) >>> 16;
      s = 2 * w[1];
      s += ((w[2] - w[0]) * u) >>> 16;
      s += ((2 * w[0] - 5 * w[1] + 4 * w[2] - w[3]) * u2) >>> 16;
      s += ((3 * w[1] - w[0] - 3 * w[2] + w[3]) * u3) >>> 16;
      return clamp_coord(s >>> 1);
   endfunction

   function automatic vertex_type make_vertex(input longint x, input longint y,
                                              input longint z, input logic poly);
      vertex_type v;
      v.x = x[cct_pkg::COORD_W-1:0];
      v.y = y[cct_pkg::COORD_W-1:0];
      v.z = z[cct_pkg::COORD_W-1:0];
      v.run_last = 1'b0;
      v.poly_last = poly;
      return v;
   endfunction

   task automatic predict_vertices(input logic signed [cct_pkg::COORD_W-1:0] px, py, pz,
                                   input logic last_pt);
      vertex_type run[$];
      int      steps, slot;
      longint  u;
      steps = steps_reg == 0 ? 1 : (steps_reg > 63 ? 63 : steps_reg);
      slot = win_count & 3;
      win_x[slot] = px;
      win_y[slot] = py;
      win_z[slot] = pz;
      win_count = slot + 1;
      if (win_count == 4) begin
         for (int k = 0; k < steps; k++) begin
            u = (longint'(k) * ONE_Q) / steps;
            run = {run, make_vertex(curve_point(win_x, u), curve_point(win_y, u),
                                    curve_point(win_z, u), 1'b0)};
         end
         tail_x = curve_point(win_x, ONE_Q);
         tail_y = curve_point(win_y, ONE_Q);
         tail_z = curve_point(win_z, ONE_Q);
         seg_done = 1'b1;
         if (last_pt) run = {run, make_vertex(tail_x, tail_y, tail_z, 1'b1)};
         if (kind_reg == cct_pkg::KIND_BEZIER) begin
            win_x[0] = win_x[3];
            win_y[0] = win_y[3];
            win_z[0] = win_z[3];
            win_count = 1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               win_x[i] = win_x[i+1];
               win_y[i] = win_y[i+1];
               win_z[i] = win_z[i+1];
            end
            win_count = 3;
         end
      end else if (last_pt && seg_done) begin
         run = {run, make_vertex(tail_x, tail_y, tail_z, 1'b1)};
      end
      if (last_pt) begin
         win_count = 0;
         seg_done = 1'b0;
      end
      if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
      vertex_q = {vertex_q, run};
   endtask

   always @(posedge clock) begin
      vertex_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vertex_q.size() == 0) begin
            $error("unexpected vertex x=%0d y=%0d z=%0d", rsp_vertex_x, rsp_vertex_y,
                   rsp_vertex_z);
            errors++;
         end else begin
            exp_v = vertex_q.pop_front();
            if (rsp_vertex_x !== exp_v.x) begin
               $error("vertex_x expected %0d actual %0d", exp_v.x, rsp_vertex_x);
               errors++;
            end
            if (rsp_vertex_y !== exp_v.y) begin
               $error("vertex_y expected %0d actual %0d", exp_v.y, rsp_vertex_y);
               errors++;
            end
            if (rsp_vertex_z !== exp_v.z) begin
               $error("vertex_z expected %0d actual %0d", exp_v.z, rsp_vertex_z);
               errors++;
            end
            if (rsp_run_last !== exp_v.run_last) begin
               $error("run_last expected %0d actual %0d", exp_v.run_last, rsp_run_last);
               errors++;
            end
            if (rsp_polyline_last !== exp_v.poly_last) begin
               $error("polyline_last expected %0d actual %0d", exp_v.poly_last,
                      rsp_polyline_last);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   // called at a falling edge; returns at a falling edge with req_valid still high
   task automatic send_point(input logic signed [cct_pkg::COORD_W-1:0] px, py, pz,
                             input logic last_pt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      req_curve_end <= last_pt;
      do @(posedge clock); while (req_stall);
      predict_vertices(px, py, pz, last_pt);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (vertex_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [cct_pkg::STEP_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == cct_pkg::CSR_CURVE_KIND) kind_reg = val[0];
      else steps_reg = int'(val);
   endtask

   task automatic set_mode(input logic kind, input logic [cct_pkg::STEP_W-1:0] steps);
      wait_drained();
      write_csr(cct_pkg::CSR_CURVE_KIND, {{(cct_pkg::STEP_W-1){1'b0}}, kind});
      write_csr(cct_pkg::CSR_STEPS, steps);
   endtask

   function automatic logic signed [cct_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_bezier_directed();
      set_mode(cct_pkg::KIND_BEZIER, 6'd16);
      send_point(0, 0, 0, 1'b1);                  // lone end point: no vertex
      send_point(32'sh7fffffff, 32'sh80000000, 0, 1'b0);
      send_point(32'sh80000000, 32'sh7fffffff, -1, 1'b0);
      send_point(32'sh7fffffff, 0, 32'sh80000000, 1'b0);
      send_point(32'sh80000000, -1, 32'sh7fffffff, 1'b1);
      // end point completes no segment: stored end vertex only
      for (int i = 0; i < 5; i++)
         send_point(i * 65536, -i * 131072, 12345, i == 4);
   endtask

   task automatic test_catmull_directed();
      set_mode(cct_pkg::KIND_CATMULL, 6'd1);
      for (int i = 0; i < 5; i++)
         send_point(i[0] ? 32'sh80000000 : 32'sh7fffffff,
                    i[0] ? 32'sh7fffffff : 32'sh80000000, -i, i == 4);
      set_mode(cct_pkg::KIND_CATMULL, 6'd63);
      for (int i = 0; i < 4; i++) send_point(rand_coord(), rand_coord(), rand_coord(), i == 3);
      set_mode(cct_pkg::KIND_BEZIER, 6'd0);       // zero steps acts as one
      for (int i = 0; i < 5; i++) send_point(rand_coord(), rand_coord(), rand_coord(), i == 4);
   endtask

   task automatic test_random_curves(input int idle, input int stall, input int n_items);
      int sent, len;
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(3) == 0)
            set_mode(1'($urandom_range(1)),
                     ($urandom_range(9) == 0) ? 6'd63 : 6'($urandom_range(0, 8)));
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      set_mode(cct_pkg::KIND_CATMULL, 6'd4);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 400;
      for (int i = 0; i < 20; i++) send_point(rand_coord(), rand_coord(), rand_coord(), i == 19);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_bezier_directed();
      test_catmull_directed();
      test_random_curves(0, 0, 105);
      test_random_curves(63, 0, 105);
      test_random_curves(0, 63, 105);
      test_random_curves(33, 33, 105);
      test_backpressure();
      stall_pct = 0;
      wait_drained();
      if (errors == 0 && vertex_q.size() == 0) begin
         $display("cubic_curve_tessellator_top: match");
      end else begin
         $display("cubic_curve_tessellator_top: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/cct_pkg.sv
rtl/cct_front.sv
rtl/cct_queue.sv
rtl/cct_eval.sv
rtl/cct_back.sv
rtl/cubic_curve_tessellator_top.sv
tb/sv/tb_cubic_curve_tessellator_top.sv
